### src/ifns_pkg.sv
// Package for the in-place four-neighbour smoothing block: widths, limits,
// command and register codes, reset values. No dependencies.
`default_nettype none

package ifns_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;

  // Configuration register widths and the write data width.
  localparam int FW_W   = 11;
  localparam int FH_W   = 12;
  localparam int CFG_W  = 12;
  localparam int CIDX_W = 1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);
  localparam logic [FW_W-1:0] MAX_WIDTH_W        = FW_W'(MAX_WIDTH);

  // Register indexes on the configuration port.
  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Input commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

endpackage

`default_nettype wire

### src/ifns_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Used for the line stores; no dependencies.
`default_nettype none

module ifns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/inplace_four_neighbour_smooth_top.sv
// Top level of the in-place four-neighbour smoothing block.
// Uses ifns_pkg (constants) and ifns_ram (line stores).
`default_nettype none

// Streaming in-place smoothing pass over RGB frames in raster order. Every
// interior pixel becomes the floor of the mean of its four neighbours, per
// channel, where the left and upper neighbours are already smoothed and the
// right and lower neighbours are originals; border pixels pass unchanged.
// Results lag the input by one row: the first row gives no beats, each later
// pixel beat gives the result for the pixel above it, and after the last row
// one drain beat per pixel (command 1) returns the held last row, with
// frame_end set on the final one. The block takes one beat per clock as long
// as the result side keeps up; an accepted beat waits in stage 1 and its
// result then goes into the result register. The pace is set by the
// registered read of the line stores, which is issued on the accepting edge
// and used in the following cycle, where the four-input adds per channel sit
// in front of the result register. The result register decouples the two
// sides, so a new beat is taken while a finished result still waits. Line
// stores are not cleared after reset; they are always written before they
// are read. frame_width and frame_height should be written only while the
// block is idle, ideally between frames.

module inplace_four_neighbour_smooth_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [ifns_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [ifns_pkg::CFG_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_command,
  input  wire logic [ifns_pkg::CHAN_W-1:0]    in_red_in,
  input  wire logic [ifns_pkg::CHAN_W-1:0]    in_green_in,
  input  wire logic [ifns_pkg::CHAN_W-1:0]    in_blue_in,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [ifns_pkg::CHAN_W-1:0]    out_red_out,
  output logic      [ifns_pkg::CHAN_W-1:0]    out_green_out,
  output logic      [ifns_pkg::CHAN_W-1:0]    out_blue_out,
  output logic                                out_frame_end
);

  localparam int AW  = ifns_pkg::ADDR_W;
  localparam int PW  = ifns_pkg::PIX_W;
  localparam int CW  = ifns_pkg::CHAN_W;
  localparam int FWW = ifns_pkg::FW_W;
  localparam int FHW = ifns_pkg::FH_W;

  // Configuration registers.
  logic [FWW-1:0] frame_width_r;
  logic [FHW-1:0] frame_height_r;

  // Position counters, advanced on the accepting edge.
  logic [AW-1:0]  column_count_r, column_count_nxt;
  logic [FHW-1:0] row_count_r,    row_count_nxt;
  logic [AW-1:0]  drain_count_r,  drain_count_nxt;

  // Stage 1: the accepted beat while its line store reads complete.
  logic           s1_vld_r;
  logic           s1_emit_r;      // beat produces a result
  logic           s1_orig_wr_r;   // pixel goes into the original store
  logic           s1_smooth_wr_r; // result goes into the smoothed store
  logic           s1_border_r;
  logic           s1_last_r;
  logic [AW-1:0]  s1_x_r;
  logic [PW-1:0]  s1_px_r;

  // Forwarding of a write that lands on the same edge as a read.
  logic           fwd_a_r, fwd_b_r, fwd_s_r;
  logic [PW-1:0]  fwd_orig_r, fwd_smooth_r;

  logic [PW-1:0]  left_smoothed_r;

  // Result register.
  logic           out_valid_r;
  logic [PW-1:0]  out_pix_r;
  logic           out_frame_end_r;

  // Effective frame size.
  logic [FWW-1:0] w_eff;
  logic [FHW-1:0] h_eff;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = FWW'(1);
    end else if (frame_width_r > ifns_pkg::MAX_WIDTH_W) begin
      w_eff = ifns_pkg::MAX_WIDTH_W;
    end else begin
      w_eff = frame_width_r;
    end
    h_eff = (frame_height_r == '0) ? FHW'(1) : frame_height_r;
  end

  // Handshake. Stage 1 retires when it has no result to give or the
  // result register is free or being emptied this cycle.
  logic s1_fire, accept, out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_vld_r && (!s1_emit_r || out_free);
  assign in_stall = s1_vld_r && !s1_fire;
  assign accept   = in_valid && !in_stall;

  // Decisions that depend only on the counters are made at acceptance.
  logic           pending;
  logic [FWW-1:0] col_plus1, drain_plus1;
  logic           row_end, drain_last;
  logic           is_drain;
  logic           d_emit, d_orig_wr, d_smooth_wr, d_border;
  logic [AW-1:0]  d_x;
  logic [AW-1:0]  rd_addr_a, rd_addr_b, rd_addr_s;

  assign pending     = row_count_r >= h_eff;
  assign col_plus1   = FWW'(column_count_r) + FWW'(1);
  assign drain_plus1 = FWW'(drain_count_r) + FWW'(1);
  assign row_end     = col_plus1 >= w_eff;
  assign drain_last  = drain_plus1 >= w_eff;
  assign is_drain    = (in_command == ifns_pkg::CMD_DRAIN);

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    drain_count_nxt  = drain_count_r;
    d_emit           = 1'b0;
    d_orig_wr        = 1'b0;
    d_smooth_wr      = 1'b0;
    d_border         = 1'b0;
    d_x              = column_count_r;
    if (is_drain) begin
      d_x = drain_count_r;
      if (pending) begin
        d_emit = 1'b1;
        if (drain_last) begin
          drain_count_nxt  = '0;
          row_count_nxt    = '0;
          column_count_nxt = '0;
        end else begin
          drain_count_nxt = drain_count_r + AW'(1);
        end
      end
    end else if (!pending) begin
      d_orig_wr = 1'b1;
      if (row_count_r != '0) begin
        d_emit      = 1'b1;
        d_smooth_wr = 1'b1;
        // The row being output is the top row, or this is an edge column.
        d_border = (row_count_r == FHW'(1)) || (column_count_r == '0) || row_end;
      end
      if (row_end) begin
        column_count_nxt = '0;
        row_count_nxt    = row_count_r + FHW'(1);
        drain_count_nxt  = '0;
      end else begin
        column_count_nxt = column_count_r + AW'(1);
      end
    end
  end

  assign rd_addr_a = d_x;
  assign rd_addr_b = column_count_r + AW'(1);
  assign rd_addr_s = column_count_r;

  // Stage 1 datapath.
  logic [PW-1:0] orig_a_q, orig_b_q, smooth_q;
  logic [PW-1:0] center, right, up, avg, res;
  logic          orig_we, smooth_we;

  assign center = fwd_a_r ? fwd_orig_r   : orig_a_q;
  assign right  = fwd_b_r ? fwd_orig_r   : orig_b_q;
  assign up     = fwd_s_r ? fwd_smooth_r : smooth_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CW+1:0] sum;
      sum = (CW+2)'(left_smoothed_r[c*CW +: CW]) + (CW+2)'(right[c*CW +: CW])
          + (CW+2)'(up[c*CW +: CW]) + (CW+2)'(s1_px_r[c*CW +: CW]);
      avg[c*CW +: CW] = sum[CW+1:2];
    end
  end

  // Drain beats and border pixels both give the stored original.
  assign res       = (s1_border_r || !s1_smooth_wr_r) ? center : avg;
  assign orig_we   = s1_fire && s1_orig_wr_r;
  assign smooth_we = s1_fire && s1_smooth_wr_r;

  ifns_ram #(.WIDTH(PW), .DEPTH(ifns_pkg::MAX_WIDTH)) u_orig_a (
    .clk   (clk),
    .we    (orig_we),
    .waddr (s1_x_r),
    .wdata (s1_px_r),
    .re    (accept),
    .raddr (rd_addr_a),
    .rdata (orig_a_q)
  );

  ifns_ram #(.WIDTH(PW), .DEPTH(ifns_pkg::MAX_WIDTH)) u_orig_b (
    .clk   (clk),
    .we    (orig_we),
    .waddr (s1_x_r),
    .wdata (s1_px_r),
    .re    (accept),
    .raddr (rd_addr_b),
    .rdata (orig_b_q)
  );

  ifns_ram #(.WIDTH(PW), .DEPTH(ifns_pkg::MAX_WIDTH)) u_smooth (
    .clk   (clk),
    .we    (smooth_we),
    .waddr (s1_x_r),
    .wdata (res),
    .re    (accept),
    .raddr (rd_addr_s),
    .rdata (smooth_q)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= ifns_pkg::FRAME_WIDTH_RESET;
      frame_height_r  <= ifns_pkg::FRAME_HEIGHT_RESET;
      column_count_r  <= '0;
      row_count_r     <= '0;
      drain_count_r   <= '0;
      s1_vld_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      left_smoothed_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ifns_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FWW-1:0];
          ifns_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FHW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        column_count_r <= column_count_nxt;
        row_count_r    <= row_count_nxt;
        drain_count_r  <= drain_count_nxt;
        s1_vld_r       <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (smooth_we) begin
        left_smoothed_r <= res;
      end
      if (s1_fire && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r      <= d_emit;
      s1_orig_wr_r   <= d_orig_wr;
      s1_smooth_wr_r <= d_smooth_wr;
      s1_border_r    <= d_border;
      s1_last_r      <= is_drain && drain_last;
      s1_x_r         <= d_x;
      s1_px_r        <= {in_red_in, in_green_in, in_blue_in};
      // A write retiring on this edge is not seen by the RAM read.
      fwd_a_r        <= orig_we && (s1_x_r == rd_addr_a);
      fwd_b_r        <= orig_we && (s1_x_r == rd_addr_b);
      fwd_s_r        <= smooth_we && (s1_x_r == rd_addr_s);
      fwd_orig_r     <= s1_px_r;
      fwd_smooth_r   <= res;
    end
    if (s1_fire && s1_emit_r) begin
      out_pix_r       <= res;
      out_frame_end_r <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r[2*CW +: CW];
  assign out_green_out = out_pix_r[CW +: CW];
  assign out_blue_out  = out_pix_r[0 +: CW];
  assign out_frame_end = out_frame_end_r;

endmodule

`default_nettype wire

### bench/ifns_smooth_scoreboard.sv
// Scoreboard for the in-place four-neighbour smoothing block: a cycle-free
// predictor of the smoothing pass and the queue of results it still owes.
// Depends on ifns_pkg for widths, command codes and register indexes.
`default_nettype none

package ifns_smooth_scoreboard_pkg;
  import ifns_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;
  } smooth_beat_t;

  class smooth_scoreboard;
    logic [PIX_W-1:0] orig_row [MAX_WIDTH];
    logic [PIX_W-1:0] smooth_row [MAX_WIDTH];
    logic [PIX_W-1:0] left_px;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    int unsigned      drain_cnt;
    int unsigned      width_reg;
    int unsigned      height_reg;
    smooth_beat_t     smoothed_due_q[$];
    int unsigned      mismatches;

    function new();
      foreach (orig_row[i]) begin
        orig_row[i]   = '0;
        smooth_row[i] = '0;
      end
      left_px    = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      drain_cnt  = 0;
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      mismatches = 0;
    endfunction

    function void set_geometry_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH) begin
        width_reg = data[FW_W-1:0];
      end else if (idx == CFG_FRAME_HEIGHT) begin
        height_reg = data[FH_W-1:0];
      end
    endfunction

    // Returns 1 when the beat is taken, 0 when the block ignores it.
    function bit absorb_pixel_beat(logic cmd, logic [PIX_W-1:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      x;
      logic [PIX_W-1:0] res;
      logic [PIX_W-1:0] right;
      logic [PIX_W-1:0] above;
      logic [9:0]       sum;
      bit               pending;
      bit               border;
      bit               last;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      pending = (row_cnt >= h);
      if (cmd == CMD_DRAIN) begin
        if (!pending) return 0;
        x    = drain_cnt % MAX_WIDTH;
        last = (drain_cnt + 1 >= w);
        smoothed_due_q.push_back(smooth_beat_t'({orig_row[x], last}));
        if (last) begin
          drain_cnt = 0;
          row_cnt   = 0;
          col_cnt   = 0;
        end else begin
          drain_cnt++;
        end
        return 1;
      end
      if (pending) return 0;
      x = col_cnt % MAX_WIDTH;
      if (row_cnt > 0) begin
        // The row being finished is row_cnt - 1.
        border = (row_cnt == 1) || (row_cnt >= h) || (x == 0) || (x + 1 >= w);
        if (border) begin
          res = orig_row[x];
        end else begin
          right = orig_row[(x + 1) % MAX_WIDTH];
          above = smooth_row[x];
          for (int sh = 0; sh <= 16; sh += 8) begin
            sum = {2'b00, left_px[sh +: 8]} + {2'b00, right[sh +: 8]} +
                  {2'b00, above[sh +: 8]} + {2'b00, px[sh +: 8]};
            res[sh +: 8] = sum[9:2];
          end
        end
        smooth_row[x] = res;
        left_px       = res;
        smoothed_due_q.push_back(smooth_beat_t'({res, 1'b0}));
      end
      orig_row[x] = px;
      if (col_cnt + 1 >= w) begin
        col_cnt   = 0;
        row_cnt++;
        drain_cnt = 0;
      end else begin
        col_cnt++;
      end
      return 1;
    endfunction

    function void report_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_smoothed_beat(smooth_beat_t got);
      smooth_beat_t want;
      if (smoothed_due_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
        return;
      end
      want = smoothed_due_q.pop_front();
      report_field("red", want.red, got.red);
      report_field("green", want.green, got.green);
      report_field("blue", want.blue, got.blue);
      report_field("frame_end", {7'b0, want.frame_end}, {7'b0, got.frame_end});
    endfunction

    function int unsigned outstanding();
      return smoothed_due_q.size();
    endfunction
  endclass

endpackage

`default_nettype wire

### bench/inplace_four_neighbour_smooth_top_test.sv
// Self-checking bench for inplace_four_neighbour_smooth_top: drives frames with
// random stalls on both sides and compares every result beat to a predictor.
// Depends on ifns_pkg, ifns_smooth_scoreboard_pkg and the block's RTL.
`default_nettype none

module inplace_four_neighbour_smooth_top_test;
  import ifns_pkg::*;
  import ifns_smooth_scoreboard_pkg::*;

  // Watchdog bound on the length of the whole run, set with a wide margin.
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_BEATS  = 800;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic              in_command;
  logic [CHAN_W-1:0] in_red_in;
  logic [CHAN_W-1:0] in_green_in;
  logic [CHAN_W-1:0] in_blue_in;
  logic              out_valid;
  logic              out_stall;
  logic [CHAN_W-1:0] out_red_out;
  logic [CHAN_W-1:0] out_green_out;
  logic [CHAN_W-1:0] out_blue_out;
  logic              out_frame_end;

  smooth_scoreboard sb;

  // Knobs shared between the stimulus and the result side.
  bit          reset_done = 1'b0;
  bit          gaps_on    = 1'b1;
  bit          stalls_on  = 1'b1;
  int unsigned hold_len   = 0;
  int unsigned taken_beats = 0;
  int unsigned cycle_cnt  = 0;

  inplace_four_neighbour_smooth_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_frame_end (out_frame_end)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Channel values lean toward the extremes so that sums of 4 x 255 and
  // all-zero neighbourhoods show up often.
  function automatic logic [PIX_W-1:0] rand_px();
    logic [PIX_W-1:0] px;
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 7))
        0:       px[c*8 +: 8] = 8'h00;
        1:       px[c*8 +: 8] = 8'hFF;
        default: px[c*8 +: 8] = 8'($urandom);
      endcase
    end
    return px;
  endfunction

  // Offers one beat on the input channel and returns once it is accepted.
  // The sender idles a random number of cycles first when gaps are enabled.
  // Valid stays high from one beat to the next when there is no gap, so it
  // is never lowered and raised within the same edge.
  task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_red_in   <= px[23:16];
    in_green_in <= px[15:8];
    in_blue_in  <= px[7:0];
    do @(posedge clk); while (in_stall !== 1'b0);
    if (sb.absorb_pixel_beat(cmd, px)) taken_beats++;
  endtask

  // Brings the block to rest: no beat offered, every expected result back,
  // then a settling wait for beats that produce nothing to finish their way
  // through the pipeline.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. The enable is dropped for a cycle afterwards so that
  // back-to-back writes never assign it twice in one time step.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_geometry_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A whole well-formed frame with random content: every pixel in raster
  // order followed by one drain beat per pixel of the held last row. Now and
  // then a beat the block must ignore is slipped in: a drain while pixels are
  // still due, or a pixel while the last row waits to be drained.
  task automatic run_frame(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data);
    int unsigned ew;
    int unsigned eh;
    wait_quiet();
    write_reg(CFG_FRAME_WIDTH, w_data);
    write_reg(CFG_FRAME_HEIGHT, h_data);
    ew = w_data[FW_W-1:0];
    ew = (ew == 0) ? 1 : ((ew > MAX_WIDTH) ? MAX_WIDTH : ew);
    eh = (h_data[FH_W-1:0] == 0) ? 1 : h_data[FH_W-1:0];
    for (int unsigned i = 0; i < ew * eh; i++) begin
      if ($urandom_range(0, 24) == 0) send_beat(CMD_DRAIN, rand_px());
      send_beat(CMD_PIXEL, rand_px());
    end
    for (int unsigned i = 0; i < ew; i++) begin
      if ($urandom_range(0, 24) == 0) send_beat(CMD_PIXEL, rand_px());
      send_beat(CMD_DRAIN, rand_px());
    end
  endtask

  // Result side. Before each beat it stalls for a random number of cycles,
  // or for a long hold when the stimulus asks for one, then takes the next
  // result and hands it to the scoreboard. Outputs are sampled at the
  // accepting edge, before the block's own updates land.
  initial begin
    int unsigned stall_for;
    out_stall <= 1'b0;
    wait (reset_done);
    forever begin
      if (hold_len != 0) begin
        stall_for = hold_len;
        hold_len  = 0;
      end else begin
        stall_for = stalls_on ? $urandom_range(0, 10) : 0;
      end
      if (stall_for != 0) begin
        out_stall <= 1'b1;
        repeat (stall_for) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_smoothed_beat(smooth_beat_t'({out_red_out, out_green_out, out_blue_out,
                                             out_frame_end}));
    end
  end

  // Stimulus.
  initial begin
    int unsigned random_start;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    sb = new();
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_FRAME_WIDTH;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_command  <= CMD_PIXEL;
    in_red_in   <= '0;
    in_green_in <= '0;
    in_blue_in  <= '0;
    repeat (3) @(posedge clk);
    rst_n     <= 1'b1;
    reset_done = 1'b1;

    // Directed part. The first six pixels go in under the reset geometry:
    // they all belong to the first row of a 640-wide frame, so nothing may
    // come out.
    send_beat(CMD_PIXEL, 24'h000000);
    send_beat(CMD_PIXEL, 24'hFFFFFF);
    send_beat(CMD_PIXEL, 24'hAA55AA);
    send_beat(CMD_PIXEL, 24'h55AA55);
    send_beat(CMD_PIXEL, 24'h0F0F0F);
    send_beat(CMD_PIXEL, 24'hF0F0F0);
    // Shrinking the geometry mid-frame: the column count already passes the
    // new width, so the next pixel closes the first row.
    wait_quiet();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(4));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(3));
    send_beat(CMD_PIXEL, 24'h123456);
    // A drain with nothing held is ignored.
    send_beat(CMD_DRAIN, 24'h000000);
    // Second row: the first row comes out unchanged as border.
    send_beat(CMD_PIXEL, 24'hFFFFFF);
    send_beat(CMD_PIXEL, 24'hFFFFFF);
    send_beat(CMD_PIXEL, 24'hFFFFFF);
    send_beat(CMD_PIXEL, 24'h000000);
    // Third row: the second row's pixel in column 1 sees all-ones neighbours,
    // the widest sum the adders have to hold.
    send_beat(CMD_PIXEL, 24'h000000);
    send_beat(CMD_PIXEL, 24'hFFFFFF);
    send_beat(CMD_PIXEL, 24'h7F80FF);
    send_beat(CMD_PIXEL, 24'h800001);
    // The last row now waits, so a pixel is ignored.
    send_beat(CMD_PIXEL, 24'hFFFFFF);
    send_beat(CMD_DRAIN, 24'hFFFFFF);
    send_beat(CMD_DRAIN, 24'h000000);
    send_beat(CMD_DRAIN, 24'hFFFFFF);
    send_beat(CMD_DRAIN, 24'h000000);
    send_beat(CMD_DRAIN, 24'hFFFFFF);

    // Geometry extremes. Zero width and zero height act as one, and frames
    // below three pixels in either direction are all border.
    run_frame(CFG_W'(0), CFG_W'(4));
    run_frame(CFG_W'(6), CFG_W'(0));
    run_frame(CFG_W'(2), CFG_W'(5));
    run_frame(CFG_W'(7), CFG_W'(2));

    // Tallest frame, cut short by lowering the height once twenty rows are
    // in: the row count already passes the new height, so the frame turns
    // straight to draining.
    wait_quiet();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(3));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(4095));
    for (int i = 0; i < 60; i++) send_beat(CMD_PIXEL, rand_px());
    wait_quiet();
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(5));
    send_beat(CMD_PIXEL, rand_px());
    for (int i = 0; i < 3; i++) send_beat(CMD_DRAIN, rand_px());

    // Drain cut short: after three drain beats the width drops below the
    // drain count, so the next drain is the final one of the frame.
    wait_quiet();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(8));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(3));
    for (int i = 0; i < 24; i++) send_beat(CMD_PIXEL, rand_px());
    for (int i = 0; i < 3; i++) send_beat(CMD_DRAIN, rand_px());
    wait_quiet();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(2));
    send_beat(CMD_DRAIN, rand_px());

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender offers a beat every cycle, so the block fills up and has to
    // stall its input.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    hold_len  = 300;
    run_frame(CFG_W'(40), CFG_W'(6));

    // Random frames, mostly small and well formed, with a share of narrow
    // and out-of-range geometries and some wider rows.
    random_start = taken_beats;
    while (taken_beats - random_start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 6);
      end else if (pick == 1) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(0, 2);
      end else if (pick == 2) begin
        w = $urandom_range(17, 80);
        h = $urandom_range(3, 4);
      end else begin
        w = $urandom_range(3, 16);
        h = $urandom_range(3, 10);
      end
      // Bit 11 of the write data lies outside the width register.
      if ($urandom_range(0, 7) == 0) w = w | 32'h800;
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      run_frame(CFG_W'(w), CFG_W'(h));
    end

    // Wind down: everything back, then a short tail in case a stray beat
    // still comes out.
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
